/* design/ordered_array_list_engine_defines.svh */
// ----------------------------------------------------------------------------
// ordered array list engine: assertion macros
// concurrent check wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define OALE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("oale: same-cycle check failed");

// next-cycle implication
`define OALE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("oale: next-cycle check failed");

`else

`define OALE_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define OALE_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

/* design/oale_pkg.sv */
// ----------------------------------------------------------------------------
// oale_pkg
// word widths, request and status codes of the ordered array list engine
// ----------------------------------------------------------------------------
`default_nettype none

package oale_pkg;

	// word field widths on the channels
	localparam int REQ_W   = 3;
	localparam int POS_W   = 5;
	localparam int KEY_W   = 64;
	localparam int PAY_W   = 32;
	localparam int STAT_W  = 2;
	localparam int TOTAL_W = 6;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 3'd0,
		REQ_DELETE = 3'd1,
		REQ_GET    = 3'd2,
		REQ_UPDATE = 3'd3,
		REQ_FIND   = 3'd4,
		REQ_CLEAR  = 3'd5
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_MISS  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

`default_nettype wire

/* design/oale_req_if.sv */
// ----------------------------------------------------------------------------
// oale_req_if
// request channel: valid/ready handshake carrying one request word
// ----------------------------------------------------------------------------
`default_nettype none

interface oale_req_if
	import oale_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [POS_W-1:0]   position;
	logic               at_end;
	logic [KEY_W-1:0]   item_key;
	logic [PAY_W-1:0]   item_payload;

	modport source (
		output valid, req_type, position, at_end, item_key, item_payload,
		input  ready
	);

	modport sink (
		input  valid, req_type, position, at_end, item_key, item_payload,
		output ready
	);
endinterface

`default_nettype wire

/* design/oale_rsp_if.sv */
// ----------------------------------------------------------------------------
// oale_rsp_if
// response channel: valid/ready handshake carrying one result word
// ----------------------------------------------------------------------------
`default_nettype none

interface oale_rsp_if
	import oale_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [STAT_W-1:0]    status;
	logic [POS_W-1:0]     found_position;
	logic [KEY_W-1:0]     out_key;
	logic [PAY_W-1:0]     out_payload;
	logic [TOTAL_W-1:0]   entry_total;

	modport source (
		output valid, status, found_position, out_key, out_payload, entry_total,
		input  ready
	);

	modport sink (
		input  valid, status, found_position, out_key, out_payload, entry_total,
		output ready
	);
endinterface

`default_nettype wire

/* design/oale_ram.sv */
// ----------------------------------------------------------------------------
// oale_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module oale_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* design/ordered_array_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// fixed-capacity ordered list of key/payload entries in one ram, with a
// small sequencer for insert, delete, get, update, find and clear
// ----------------------------------------------------------------------------
// One request word gives one result word. Requests are handled one at a time:
// the request side is ready only while the sequencer is idle, and a new word
// may be taken while the previous result still waits on the response side.
// All entries sit in a single ram with one write and one registered read
// port, and every shift or scan runs through that port one entry a cycle, so
// the ram port sets the rate. Clear and rejected requests touch no entry,
// a delete of the last entry moves nothing, and find stops at its first
// match. A result waits in the sequencer while the response side still
// holds the previous one. No clearing pass is needed after reset: entries
// beyond the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ordered_array_list_engine_defines.svh"

module ordered_array_list_engine
	import oale_pkg::*;
#(
	parameter int CAPACITY     = 32,
	parameter int KEY_BITS     = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	oale_req_if.sink    req,
	oale_rsp_if.source  rsp
);

	// index and count widths
	localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int XW  = (CW > POS_W) ? CW : POS_W;
	localparam int TW  = (CW > TOTAL_W) ? CW : TOTAL_W;
	localparam int FW  = (AW > POS_W) ? AW : POS_W;
	localparam int PWX = (PAYLOAD_BITS > PAY_W) ? PAYLOAD_BITS : PAY_W;
	localparam int DW  = KEY_BITS + PAYLOAD_BITS;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_MOVE    = 7'b0000010,
		S_PUT     = 7'b0000100,
		S_GET_RD  = 7'b0001000,
		S_GET_CAP = 7'b0010000,
		S_FIND    = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// control registers
	logic [CW-1:0] count_q, count_d;     // live entries
	logic [CW-1:0] cnt_nx_q, cnt_nx_d;   // count once the request completes
	logic [CW-1:0] left_q, left_d;       // reads still to issue
	logic [AW-1:0] rp_q, rp_d;           // read pointer
	logic [AW-1:0] wp_q, wp_d;           // write pointer for moved entries
	logic [AW-1:0] put_q, put_d;         // slot for the new entry
	logic [AW-1:0] cidx_q, cidx_d;       // index of the entry on the read port
	logic          pend_q, pend_d;       // read data on the port is live
	logic          up_q, up_d;           // shift direction, set for insert
	logic          ovalid_q, ovalid_d;

	// payload registers
	logic [KEY_BITS-1:0]     key_q, key_d;
	logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
	status_t                 res_st_q, res_st_d;
	logic [POS_W-1:0]        res_found_q, res_found_d;
	logic [KEY_BITS-1:0]     res_key_q, res_key_d;
	logic [PAYLOAD_BITS-1:0] res_pay_q, res_pay_d;
	status_t                 out_st_q, out_st_d;
	logic [POS_W-1:0]        out_found_q, out_found_d;
	logic [KEY_BITS-1:0]     out_key_q, out_key_d;
	logic [PAYLOAD_BITS-1:0] out_pay_q, out_pay_d;
	logic [TOTAL_W-1:0]      out_total_q, out_total_d;

	// ram port
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata, ram_rdata;
	logic [KEY_BITS-1:0]     rd_key;
	logic [PAYLOAD_BITS-1:0] rd_pay;

	// request decode helpers
	logic [XW-1:0]  pos_x, cnt_x;
	logic [AW-1:0]  pos_i;
	logic           in_range, full;
	logic [CW-1:0]  cnt_p1, cnt_m1, left_ins, left_del;
	logic [PWX-1:0] px, opx;
	logic [FW-1:0]  fx;
	logic [TW-1:0]  tx;

	oale_ram #(
		.WIDTH (DW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	assign rd_key = ram_rdata[DW-1:PAYLOAD_BITS];
	assign rd_pay = ram_rdata[PAYLOAD_BITS-1:0];

	// position against count, widened so neither side loses bits
	assign pos_x    = XW'(req.position);
	assign cnt_x    = XW'(count_q);
	assign pos_i    = pos_x[AW-1:0];
	assign in_range = pos_x < cnt_x;
	assign full     = count_q == CAP_C;
	assign cnt_p1   = count_q + CW'(1);
	assign cnt_m1   = count_q - CW'(1);
	// insert moves entries p..n-1 up, delete moves p+1..n-1 down
	assign left_ins = CW'(cnt_x - pos_x);
	assign left_del = CW'(cnt_x - pos_x - XW'(1));
	assign px       = PWX'(req.item_payload);
	assign fx       = FW'(cidx_q);
	assign tx       = TW'(cnt_nx_q);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		cnt_nx_d    = cnt_nx_q;
		left_d      = left_q;
		rp_d        = rp_q;
		wp_d        = wp_q;
		put_d       = put_q;
		cidx_d      = cidx_q;
		pend_d      = pend_q;
		up_d        = up_q;
		ovalid_d    = ovalid_q;
		key_d       = key_q;
		pay_d       = pay_q;
		res_st_d    = res_st_q;
		res_found_d = res_found_q;
		res_key_d   = res_key_q;
		res_pay_d   = res_pay_q;
		out_st_d    = out_st_q;
		out_found_d = out_found_q;
		out_key_d   = out_key_q;
		out_pay_d   = out_pay_q;
		out_total_d = out_total_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_waddr   = wp_q;
		ram_wdata   = ram_rdata;

		// result word taken
		if (ovalid_q && rsp.ready) begin
			ovalid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					key_d       = req.item_key[KEY_BITS-1:0];
					pay_d       = px[PAYLOAD_BITS-1:0];
					res_st_d    = ST_OK;
					res_found_d = '0;
					res_key_d   = '0;
					res_pay_d   = '0;
					cnt_nx_d    = count_q;
					pend_d      = 1'b0;
					state_d     = S_DONE;
					unique case (req_t'(req.req_type))
						REQ_INSERT: begin
							// full check comes before the position check
							if (full) begin
								res_st_d = ST_FULL;
							end else if (req.at_end) begin
								put_d    = count_q[AW-1:0];
								cnt_nx_d = cnt_p1;
								state_d  = S_PUT;
							end else if (!in_range) begin
								res_st_d = ST_RANGE;
							end else begin
								put_d    = pos_i;
								rp_d     = cnt_m1[AW-1:0];
								left_d   = left_ins;
								up_d     = 1'b1;
								cnt_nx_d = cnt_p1;
								state_d  = S_MOVE;
							end
						end
						REQ_DELETE: begin
							if (!in_range) begin
								res_st_d = ST_RANGE;
							end else begin
								cnt_nx_d = cnt_m1;
								rp_d     = pos_i + AW'(1);
								left_d   = left_del;
								up_d     = 1'b0;
								// removing the last entry moves nothing
								if (left_del != '0) begin
									state_d = S_MOVE;
								end
							end
						end
						REQ_GET: begin
							if (!in_range) begin
								res_st_d = ST_RANGE;
							end else begin
								rp_d    = pos_i;
								state_d = S_GET_RD;
							end
						end
						REQ_UPDATE: begin
							if (!in_range) begin
								res_st_d = ST_RANGE;
							end else begin
								put_d   = pos_i;
								state_d = S_PUT;
							end
						end
						REQ_FIND: begin
							// miss unless a live entry matches
							res_st_d = ST_MISS;
							rp_d     = '0;
							left_d   = count_q;
							if (count_q != '0) begin
								state_d = S_FIND;
							end
						end
						REQ_CLEAR: begin
							cnt_nx_d = '0;
						end
						default: begin
							// unused codes change nothing
						end
					endcase
				end
			end
			S_MOVE: begin
				// read one entry while writing the one read in the previous cycle
				ram_re    = left_q != '0;
				ram_we    = pend_q;
				ram_waddr = wp_q;
				ram_wdata = ram_rdata;
				if (left_q != '0) begin
					pend_d = 1'b1;
					wp_d   = up_q ? rp_q + AW'(1) : rp_q - AW'(1);
					rp_d   = up_q ? rp_q - AW'(1) : rp_q + AW'(1);
					left_d = left_q - CW'(1);
				end else begin
					pend_d  = 1'b0;
					state_d = up_q ? S_PUT : S_DONE;
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = put_q;
				ram_wdata = {key_q, pay_q};
				state_d   = S_DONE;
			end
			S_GET_RD: begin
				ram_re  = 1'b1;
				state_d = S_GET_CAP;
			end
			S_GET_CAP: begin
				res_key_d = rd_key;
				res_pay_d = rd_pay;
				state_d   = S_DONE;
			end
			S_FIND: begin
				// compare the entry on the read port, fetch the next one
				ram_re = left_q != '0;
				if (pend_q && (rd_key == key_q)) begin
					res_st_d    = ST_OK;
					res_found_d = fx[POS_W-1:0];
					pend_d      = 1'b0;
					state_d     = S_DONE;
				end else if (left_q != '0) begin
					pend_d = 1'b1;
					cidx_d = rp_q;
					rp_d   = rp_q + AW'(1);
					left_d = left_q - CW'(1);
				end else begin
					pend_d  = 1'b0;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// hand the result to the output register once it is free
				if (!ovalid_q || rsp.ready) begin
					ovalid_d    = 1'b1;
					out_st_d    = res_st_q;
					out_found_d = res_found_q;
					out_key_d   = res_key_q;
					out_pay_d   = res_pay_q;
					out_total_d = tx[TOTAL_W-1:0];
					count_d     = cnt_nx_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cnt_nx_q <= '0;
			left_q   <= '0;
			rp_q     <= '0;
			wp_q     <= '0;
			put_q    <= '0;
			cidx_q   <= '0;
			pend_q   <= 1'b0;
			up_q     <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			cnt_nx_q <= cnt_nx_d;
			left_q   <= left_d;
			rp_q     <= rp_d;
			wp_q     <= wp_d;
			put_q    <= put_d;
			cidx_q   <= cidx_d;
			pend_q   <= pend_d;
			up_q     <= up_d;
			ovalid_q <= ovalid_d;
		end
	end

	// request and result words
	always_ff @(posedge clk) begin
		key_q       <= key_d;
		pay_q       <= pay_d;
		res_st_q    <= res_st_d;
		res_found_q <= res_found_d;
		res_key_q   <= res_key_d;
		res_pay_q   <= res_pay_d;
		out_st_q    <= out_st_d;
		out_found_q <= out_found_d;
		out_key_q   <= out_key_d;
		out_pay_q   <= out_pay_d;
		out_total_q <= out_total_d;
	end

	// channel outputs
	assign opx                = PWX'(out_pay_q);
	assign req.ready          = state_q == S_IDLE;
	assign rsp.valid          = ovalid_q;
	assign rsp.status         = out_st_q;
	assign rsp.found_position = out_found_q;
	assign rsp.out_key        = KEY_W'(out_key_q);
	assign rsp.out_payload    = opx[PAY_W-1:0];
	assign rsp.entry_total    = out_total_q;

	// a full answer only ever comes from a full list
	`OALE_ASSERT_IMP(a_full_cnt, clk, arst_n, rsp.valid && (rsp.status == ST_FULL), count_q == CAP_C)
	// the count moves only when a result is handed over
	`OALE_ASSERT_NXT(a_cnt_hold, clk, arst_n, state_q != S_DONE, $stable(count_q))
	// shifting never reads the slot it is writing
	`OALE_ASSERT_IMP(a_no_clash, clk, arst_n, ram_we && ram_re, ram_waddr != rp_q)
	// the ram is quiet between requests
	`OALE_ASSERT_IMP(a_idle_quiet, clk, arst_n, state_q == S_IDLE, !ram_we && !ram_re)

endmodule

`default_nettype wire

/* dv/oale_list_mirror_pkg.sv */
// ----------------------------------------------------------------------------
// oale_list_mirror_pkg
// word types and the list mirror that predicts and checks every reply
// ----------------------------------------------------------------------------
package oale_list_mirror_pkg;

	import oale_pkg::*;

	localparam int LIST_DEPTH = 32;

	typedef struct packed {
		logic [REQ_W-1:0]   kind;
		logic [POS_W-1:0]   position;
		logic               at_end;
		logic [KEY_W-1:0]   item_key;
		logic [PAY_W-1:0]   item_payload;
	} list_request_t;

	typedef struct packed {
		status_t            status;
		logic [POS_W-1:0]   found_position;
		logic [KEY_W-1:0]   out_key;
		logic [PAY_W-1:0]   out_payload;
		logic [TOTAL_W-1:0] entry_total;
	} list_reply_t;

	class list_mirror;
		logic [KEY_W-1:0] keys [LIST_DEPTH];
		logic [PAY_W-1:0] payloads [LIST_DEPTH];
		int unsigned      count;
		list_reply_t      pending_replies [$];
		int unsigned      mismatches;
		int unsigned      replies_checked;
		int unsigned      kinds_seen [8];
		int unsigned      status_seen [4];

		function new();
			foreach (keys[i]) begin
				keys[i] = '0;
				payloads[i] = '0;
			end
			foreach (kinds_seen[i])
				kinds_seen[i] = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
			count = 0;
			mismatches = 0;
			replies_checked = 0;
		endfunction

		// apply one accepted request word and queue the reply it must give
		function void take_request(list_request_t r);
			list_reply_t want;
			bit          hit;
			want = '{status: ST_OK, found_position: '0, out_key: '0,
				out_payload: '0, entry_total: '0};
			hit = 1'b0;
			case (r.kind)
				REQ_INSERT: begin
					if (count >= LIST_DEPTH)
						want.status = ST_FULL;
					else if (r.at_end) begin
						keys[count] = r.item_key;
						payloads[count] = r.item_payload;
						count++;
					end else if (r.position >= count)
						want.status = ST_RANGE;
					else begin
						for (int i = int'(count); i > int'(r.position); i--) begin
							keys[i] = keys[i-1];
							payloads[i] = payloads[i-1];
						end
						keys[r.position] = r.item_key;
						payloads[r.position] = r.item_payload;
						count++;
					end
				end
				REQ_DELETE: begin
					if (r.position >= count)
						want.status = ST_RANGE;
					else begin
						for (int i = int'(r.position); i + 1 < int'(count); i++) begin
							keys[i] = keys[i+1];
							payloads[i] = payloads[i+1];
						end
						count--;
					end
				end
				REQ_GET: begin
					if (r.position >= count)
						want.status = ST_RANGE;
					else begin
						want.out_key = keys[r.position];
						want.out_payload = payloads[r.position];
					end
				end
				REQ_UPDATE: begin
					if (r.position >= count)
						want.status = ST_RANGE;
					else begin
						keys[r.position] = r.item_key;
						payloads[r.position] = r.item_payload;
					end
				end
				REQ_FIND: begin
					want.status = ST_MISS;
					for (int i = 0; i < int'(count); i++) begin
						if (!hit && keys[i] == r.item_key) begin
							hit = 1'b1;
							want.status = ST_OK;
							want.found_position = POS_W'(i);
						end
					end
				end
				REQ_CLEAR:
					count = 0;
				default: ;
			endcase
			want.entry_total = TOTAL_W'(count);
			pending_replies.push_back(want);
			kinds_seen[r.kind]++;
		endfunction

		task report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
			mismatches++;
			$display("mismatch on reply %0d: %s got %0h want %0h", replies_checked, what,
				got, want);
		endtask

		// compare one accepted reply word with the oldest queued one
		task match_reply(list_reply_t got);
			list_reply_t want;
			replies_checked++;
			if (pending_replies.size() == 0) begin
				report_mismatch("reply with nothing outstanding", KEY_W'(got.status), '0);
				return;
			end
			want = pending_replies.pop_front();
			status_seen[want.status]++;
			if (got.status !== want.status)
				report_mismatch("status", KEY_W'(got.status), KEY_W'(want.status));
			if (got.found_position !== want.found_position)
				report_mismatch("found_position", KEY_W'(got.found_position),
					KEY_W'(want.found_position));
			if (got.out_key !== want.out_key)
				report_mismatch("out_key", got.out_key, want.out_key);
			if (got.out_payload !== want.out_payload)
				report_mismatch("out_payload", KEY_W'(got.out_payload),
					KEY_W'(want.out_payload));
			if (got.entry_total !== want.entry_total)
				report_mismatch("entry_total", KEY_W'(got.entry_total),
					KEY_W'(want.entry_total));
		endtask
	endclass

endpackage

/* dv/ordered_array_list_engine_test.sv */
// ----------------------------------------------------------------------------
// ordered_array_list_engine_test
// drives request words into the list engine, mirrors the list contents and
// checks every reply word field by field under several idling patterns
// ----------------------------------------------------------------------------
module ordered_array_list_engine_test;

	timeunit 1ns;
	timeprecision 1ps;

	import oale_pkg::*;
	import oale_list_mirror_pkg::*;

	// request codes the engine does not define; they must change nothing
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	localparam int RANDOM_WORDS = 500;
	localparam int PHASE_WORDS  = RANDOM_WORDS / 4;
	// limit covers the longest request plus sender gap and receiver stall
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int GAP_CAP      = 200;

	logic clk;
	logic arst_n;

	oale_req_if req_ch ();
	oale_rsp_if rsp_ch ();

	ordered_array_list_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_mirror  mirror;
	logic [KEY_W-1:0] key_pool [8];
	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned idle_cycles;
	bit          growing;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: ready is redrawn at every falling edge
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready = ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// reply words are taken at the rising edge and checked at once
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			mirror.match_reply('{status: status_t'(rsp_ch.status),
				found_position: rsp_ch.found_position, out_key: rsp_ch.out_key,
				out_payload: rsp_ch.out_payload, entry_total: rsp_ch.entry_total});
	end

	// watchdog: a long run of cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic list_request_t word_of(logic [REQ_W-1:0] kind,
		logic [POS_W-1:0] position, logic at_end, logic [KEY_W-1:0] item_key,
		logic [PAY_W-1:0] item_payload);
		list_request_t r;
		r.kind = kind;
		r.position = position;
		r.at_end = at_end;
		r.item_key = item_key;
		r.item_payload = item_payload;
		return r;
	endfunction

	// mostly a live position, now and then one at or past the count unless full
	function automatic logic [POS_W-1:0] pick_position(int unsigned n);
		if (n == 0 || $urandom_range(0, 9) == 0)
			return (n >= LIST_DEPTH) ? POS_W'($urandom_range(0, 31)) :
				POS_W'($urandom_range(n, 31));
		return POS_W'($urandom_range(0, n - 1));
	endfunction

	// pool keys give duplicates, so find has to return the first match
	function automatic logic [KEY_W-1:0] pick_key(bit from_list);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (from_list && mirror.count > 0 && roll < 50)
			return mirror.keys[$urandom_range(0, mirror.count - 1)];
		if (roll < 75)
			return key_pool[$urandom_range(0, 7)];
		return {$urandom(), $urandom()};
	endfunction

	// random word; the mix swings between filling the list and draining it
	function automatic list_request_t make_request();
		list_request_t r;
		int unsigned   roll;
		int unsigned   n;
		n = mirror.count;
		r = word_of(REQ_INSERT, pick_position(n), 1'($urandom_range(0, 1)),
			pick_key(1'b0), $urandom());
		if (growing && n >= LIST_DEPTH) begin
			// one insert into the full list, then start draining
			growing = 1'b0;
			return r;
		end
		if (!growing && n == 0)
			growing = 1'b1;
		roll = $urandom_range(0, 99);
		if (growing) begin
			if (roll < 55)      r.kind = REQ_INSERT;
			else if (roll < 65) r.kind = REQ_DELETE;
			else if (roll < 75) r.kind = REQ_GET;
			else if (roll < 83) r.kind = REQ_UPDATE;
			else if (roll < 96) r.kind = REQ_FIND;
			else if (roll < 97) r.kind = REQ_CLEAR;
			else if (roll < 98) r.kind = REQ_SPARE_LO;
			else                r.kind = REQ_SPARE_HI;
		end else begin
			if (roll < 15)      r.kind = REQ_INSERT;
			else if (roll < 58) r.kind = REQ_DELETE;
			else if (roll < 70) r.kind = REQ_GET;
			else if (roll < 78) r.kind = REQ_UPDATE;
			else if (roll < 94) r.kind = REQ_FIND;
			else if (roll < 97) r.kind = REQ_CLEAR;
			else if (roll < 98) r.kind = REQ_SPARE_LO;
			else                r.kind = REQ_SPARE_HI;
		end
		if (r.kind == REQ_FIND)
			r.item_key = pick_key(1'b1);
		return r;
	endfunction

	// entered and left at a falling edge; valid stays high into the next
	// word when there is no gap
	task automatic send_request(list_request_t r);
		int gap;
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.req_type = r.kind;
		req_ch.position = r.position;
		req_ch.at_end = r.at_end;
		req_ch.item_key = r.item_key;
		req_ch.item_payload = r.item_payload;
		req_ch.valid = 1'b1;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		mirror.take_request(r);
		@(negedge clk);
	endtask

	initial begin
		mirror = new();
		growing = 1'b1;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		idle_cycles = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			key_pool[i] = {$urandom(), $urandom()};

		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_CLEAR;
		req_ch.position = '0;
		req_ch.at_end = 1'b0;
		req_ch.item_key = '0;
		req_ch.item_payload = '0;

		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty list first, every position check must reject
		send_request(word_of(REQ_FIND, '0, 1'b0, '0, '0));
		send_request(word_of(REQ_GET, '0, 1'b0, '0, '0));
		send_request(word_of(REQ_DELETE, '0, 1'b0, '0, '0));
		send_request(word_of(REQ_UPDATE, '0, 1'b0, '1, '1));
		send_request(word_of(REQ_INSERT, '0, 1'b0, key_pool[2], 32'h1));
		// appends with the extreme keys and payloads, position ignored
		send_request(word_of(REQ_INSERT, '1, 1'b1, '1, '1));
		send_request(word_of(REQ_INSERT, '0, 1'b1, '0, '0));
		// insert at the head and in the middle, then a duplicate key
		send_request(word_of(REQ_INSERT, '0, 1'b0, key_pool[2], 32'h2));
		send_request(word_of(REQ_INSERT, 5'd1, 1'b0, key_pool[3], 32'h3));
		send_request(word_of(REQ_INSERT, 5'd17, 1'b1, key_pool[2], 32'h4));
		send_request(word_of(REQ_GET, '0, 1'b0, '0, '0));
		send_request(word_of(REQ_GET, 5'd4, 1'b0, '0, '0));
		send_request(word_of(REQ_UPDATE, 5'd1, 1'b0, key_pool[4], 32'hA5A5_5A5A));
		send_request(word_of(REQ_FIND, '1, 1'b1, key_pool[2], '0));
		send_request(word_of(REQ_FIND, '0, 1'b0, '1, '0));
		send_request(word_of(REQ_FIND, '0, 1'b0, key_pool[5], '0));
		// delete the last entry, then the first
		send_request(word_of(REQ_DELETE, 5'd4, 1'b0, '0, '0));
		send_request(word_of(REQ_DELETE, '0, 1'b0, '0, '0));
		send_request(word_of(REQ_GET, '1, 1'b0, '0, '0));
		send_request(word_of(REQ_SPARE_LO, 5'd2, 1'b1, '1, '1));
		send_request(word_of(REQ_SPARE_HI, '1, 1'b0, '0, '1));
		// clear keeps the old entries, but find must not see them
		send_request(word_of(REQ_CLEAR, '0, 1'b0, '0, '0));
		send_request(word_of(REQ_GET, '0, 1'b0, '0, '0));
		send_request(word_of(REQ_FIND, '0, 1'b0, key_pool[4], '0));
		send_request(word_of(REQ_INSERT, '1, 1'b1, key_pool[6], $urandom()));

		// random part in four idling phases; each filling swing runs until the
		// list is full
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			case (i / PHASE_WORDS)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 77;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 77;
				end
				default: begin
					tx_idle_pct = 6;
					rx_stall_pct = 6;
				end
			endcase
			send_request(make_request());
		end
		req_ch.valid = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;

		// drain, then watch for stray replies; the watchdog bounds the wait
		while (mirror.pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d replies: %0d inserts, %0d deletes, %0d gets, %0d updates, %0d finds, %0d clears, %0d spare codes",
			mirror.replies_checked, mirror.kinds_seen[REQ_INSERT],
			mirror.kinds_seen[REQ_DELETE], mirror.kinds_seen[REQ_GET],
			mirror.kinds_seen[REQ_UPDATE], mirror.kinds_seen[REQ_FIND],
			mirror.kinds_seen[REQ_CLEAR],
			mirror.kinds_seen[REQ_SPARE_LO] + mirror.kinds_seen[REQ_SPARE_HI]);
		$display("status mix: %0d ok, %0d full, %0d not found, %0d out of range; %0d mismatches",
			mirror.status_seen[ST_OK], mirror.status_seen[ST_FULL],
			mirror.status_seen[ST_MISS], mirror.status_seen[ST_RANGE], mirror.mismatches);
		if (mirror.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/oale_pkg.sv
design/oale_req_if.sv
design/oale_rsp_if.sv
design/oale_ram.sv
design/ordered_array_list_engine.sv
dv/oale_list_mirror_pkg.sv
dv/ordered_array_list_engine_test.sv
